FILE: rtl/dhb_pkg.sv
// dhb_pkg: shared types, codes and constants for the dual H-bridge PWM block.
// No dependencies; imported by every module under rtl/.
package dhb_pkg;

   // PWM counter width and the width used for counter/compare/period compares
   localparam int CNT_W = 16;
   localparam int CMP_W = (CNT_W > 16) ? CNT_W : 16;

   // command queue between the front and back parts
   localparam int QDEPTH = 8;
   localparam int QADDR_W = $clog2(QDEPTH);
   localparam int QCNT_W = QADDR_W + 1;
   localparam int CRED_W = QCNT_W + 1;

   // speed arithmetic
   localparam int MAG_W = 10;
   localparam int PROD_W = MAG_W + 16;
   localparam int RECIP_W = 24;
   localparam int QF_W = PROD_W - 3 + RECIP_W;
   // x / 1000 == (x >> 3) / 125, and (y * RECIP_125) >> RECIP_SHIFT == y / 125
   // exactly for every y below 2^23
   localparam logic [RECIP_W-1:0] RECIP_125 = 24'd8589935;
   localparam int RECIP_SHIFT = 30;
   localparam logic [MAG_W-1:0] MAG_MAX = 10'd1000;
   localparam logic signed [15:0] CMD_MAX = 16'sd1000;
   localparam logic signed [15:0] CMD_MIN = -16'sd1000;

   // register indexes
   localparam logic [1:0] CSR_PERIOD = 2'd0;
   localparam logic [1:0] CSR_DEADBAND = 2'd1;
   localparam logic [1:0] CSR_BRAKE = 2'd2;

   localparam logic [15:0] PERIOD_RESET = 16'd500;

   typedef enum logic [2:0] {
      OP_TICK  = 3'd0,
      OP_SET   = 3'd1,
      OP_COAST = 3'd2,
      OP_BRAKE = 3'd3,
      OP_SLEEP = 3'd4,
      OP_WAKE  = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      MODE_LOW  = 2'd0,
      MODE_HIGH = 2'd1,
      MODE_PWM  = 2'd2
   } mode_type;

   typedef struct packed {
      logic [2:0]        opcode;
      logic signed [15:0] left_command;
      logic signed [15:0] right_command;
   } req_type;

   typedef struct packed {
      logic left_in1;
      logic left_in2;
      logic right_in1;
      logic right_in2;
      logic sleep_n;
   } rsp_type;

   typedef struct packed {
      logic [15:0]      pwm_period;
      logic [MAG_W-1:0] deadband;
      logic             stop_brake;
   } cfg_type;

   // one bridge of a decoded set command
   typedef struct packed {
      logic        stop;
      logic        fwd;
      logic [15:0] cmp;
   } bridge_cmd_type;

   typedef struct packed {
      logic [2:0]                op;
      bridge_cmd_type [1:0]      br;   // [0] left, [1] right
   } queue_entry_type;

   typedef struct packed {
      logic       push;
      logic [1:0] inflight;
   } front_status_type;

   // clamp to -1000..1000 and return the magnitude
   function automatic logic [MAG_W-1:0] clamp_mag(input logic signed [15:0] v);
      logic [15:0] neg;
      neg = 16'(-v);
      if (v < CMD_MIN || v > CMD_MAX) begin
         return MAG_MAX;
      end else if (v[15]) begin
         return neg[MAG_W-1:0];
      end else begin
         return v[MAG_W-1:0];
      end
   endfunction

endpackage

FILE: rtl/dual_hbridge_slow_decay_pwm.sv
// dual_hbridge_slow_decay_pwm: top level of the dual H-bridge slow-decay PWM
// driver. Instantiates dhb_front, dhb_fifo and dhb_back; uses dhb_pkg.
//
// Usage:
//  - req_* carries one command transaction (tick, set speeds, coast all,
//    brake all, sleep, wake) under valid/ready. Every accepted transaction
//    yields exactly one rsp_* transaction with the four pin levels and
//    sleep_n as they stand after that command.
//  - csr_* is a write-only register port (period, deadband, stop_brake);
//    write it only while no transaction is in flight.
//  - A request passes three front stages (set-command arithmetic), one queue
//    write and one back/result register before its response shows, and
//    waits longer if rsp_ready is held low.
//  - Throughput: one transaction per clock. The front pipeline never stalls;
//    req_ready is a credit check so the 8-entry queue can never overflow.
//  - When the receiver stalls, the result register holds and the queue
//    fills; req_ready drops once queue plus in-flight front items reach 8.
//  - Reset (synchronous, active high) empties the pipeline and queue,
//    restores period 500, deadband 0, coast on stop, counter 0, all pins
//    coasting and the driver awake.
module dual_hbridge_slow_decay_pwm (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dhb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dhb_pkg::rsp_type rsp_data,
   input  logic             csr_write_en,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata
);
   import dhb_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   front_status_type front_status;
   queue_entry_type  push_data;
   queue_entry_type  q_head;
   logic             q_valid;
   logic             pop;
   logic [QCNT_W-1:0] q_count;
   logic [CRED_W-1:0] credits_used;
   logic             req_accept;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_PERIOD:   cfg_in.pwm_period = csr_wdata;
            CSR_DEADBAND: cfg_in.deadband   = csr_wdata[MAG_W-1:0];
            CSR_BRAKE:    cfg_in.stop_brake = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pwm_period <= PERIOD_RESET;
         cfg_ff.deadband   <= '0;
         cfg_ff.stop_brake <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // credit check: queue entries plus items still in the front pipeline
   assign credits_used = CRED_W'(q_count) + CRED_W'(front_status.inflight);
   assign req_ready    = credits_used < CRED_W'(QDEPTH);
   assign req_accept   = req_valid && req_ready;

   dhb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_accept),
      .in_data   (req_data),
      .status    (front_status),
      .push_data (push_data)
   );

   dhb_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_status.push),
      .push_data (push_data),
      .pop       (pop),
      .not_empty (q_valid),
      .head      (q_head),
      .count     (q_count)
   );

   dhb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credits_used <= CRED_W'(QDEPTH))
      else $error("queue credits exceeded");
`endif

endmodule

FILE: rtl/dhb_front.sv
// dhb_front: accepts transactions and turns set commands into per-bridge
// stop/direction/compare values over three pipeline stages. Uses dhb_pkg.
module dhb_front (
   input  logic                      clock,
   input  logic                      reset,
   input  dhb_pkg::cfg_type          cfg,
   input  logic                      in_valid,
   input  dhb_pkg::req_type          in_data,
   output dhb_pkg::front_status_type status,
   output dhb_pkg::queue_entry_type  push_data
);
   import dhb_pkg::*;

   // stage 1: clamp, deadband
   logic                  s1_valid_ff, s1_valid_in;
   logic [2:0]            s1_op_ff;
   logic [1:0][MAG_W-1:0] s1_mag_ff, s1_mag_in;
   logic [1:0]            s1_neg_ff, s1_neg_in;
   // stage 2: mag * period
   logic                  s2_valid_ff;
   logic [2:0]            s2_op_ff;
   logic [1:0][PROD_W-1:0] s2_prod_ff, s2_prod_in;
   logic [1:0]            s2_neg_ff, s2_zero_ff, s2_zero_in;
   // stage 3: divide by 1000
   logic                  s3_valid_ff;
   logic [2:0]            s3_op_ff;
   logic [1:0][15:0]      s3_duty_ff, s3_duty_in;
   logic [1:0]            s3_neg_ff, s3_zero_ff;
   logic [1:0][QF_W-1:0]  qf;
   logic signed [15:0]    cmd [2];

   assign cmd[0] = in_data.left_command;
   assign cmd[1] = in_data.right_command;
   assign s1_valid_in = in_valid;

   always_comb begin
      for (int b = 0; b < 2; b++) begin
         s1_mag_in[b] = clamp_mag(cmd[b]);
         if (s1_mag_in[b] < cfg.deadband) begin
            s1_mag_in[b] = '0;
         end
         s1_neg_in[b] = cmd[b][15];
         s2_prod_in[b] = PROD_W'(s1_mag_ff[b]) * PROD_W'(cfg.pwm_period);
         s2_zero_in[b] = (s1_mag_ff[b] == '0);
         qf[b] = QF_W'(s2_prod_ff[b][PROD_W-1:3]) * QF_W'(RECIP_125);
         s3_duty_in[b] = qf[b][RECIP_SHIFT +: 16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff   <= in_data.opcode;
      s1_mag_ff  <= s1_mag_in;
      s1_neg_ff  <= s1_neg_in;
      s2_op_ff   <= s1_op_ff;
      s2_prod_ff <= s2_prod_in;
      s2_neg_ff  <= s1_neg_ff;
      s2_zero_ff <= s2_zero_in;
      s3_op_ff   <= s2_op_ff;
      s3_duty_ff <= s3_duty_in;
      s3_neg_ff  <= s2_neg_ff;
      s3_zero_ff <= s2_zero_ff;
   end

   always_comb begin
      push_data.op = s3_op_ff;
      for (int b = 0; b < 2; b++) begin
         push_data.br[b].stop = s3_zero_ff[b] || (s3_duty_ff[b] == '0);
         push_data.br[b].fwd  = !s3_neg_ff[b];
         push_data.br[b].cmp  = cfg.pwm_period - s3_duty_ff[b];
      end
      status.push = s3_valid_ff;
      status.inflight = 2'({1'b0, s1_valid_ff} + {1'b0, s2_valid_ff} + {1'b0, s3_valid_ff});
   end

endmodule

FILE: rtl/dhb_fifo.sv
// dhb_fifo: short command queue between the front and back parts.
// Uses dhb_pkg for the entry type and depth.
module dhb_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  dhb_pkg::queue_entry_type push_data,
   input  logic                     pop,
   output logic                     not_empty,
   output dhb_pkg::queue_entry_type head,
   output logic [dhb_pkg::QCNT_W-1:0] count
);
   import dhb_pkg::*;

   queue_entry_type       mem [QDEPTH];
   logic [QADDR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QADDR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QADDR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QADDR_W'(1) : rd_ptr_ff;
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   assign head = mem[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count = count_ff;

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < QCNT_W'(QDEPTH)) || pop)
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue pop while empty");
`endif

endmodule

FILE: rtl/dhb_back.sv
// dhb_back: bridge state (counter, pin modes, compares, sleep) and the
// registered result stage. Uses dhb_pkg.
module dhb_back (
   input  logic                     clock,
   input  logic                     reset,
   input  dhb_pkg::cfg_type         cfg,
   input  logic                     q_valid,
   input  dhb_pkg::queue_entry_type q_head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output dhb_pkg::rsp_type         rsp_data
);
   import dhb_pkg::*;

   logic [CNT_W-1:0]    counter_ff, counter_in, counter_nxt;
   mode_type [3:0]      mode_ff, mode_in;
   logic [3:0][15:0]    shadow_ff, shadow_in;
   logic [3:0][15:0]    active_ff, active_in;
   logic                awake_ff, awake_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic [3:0]          level;
   mode_type            stop_mode;
   logic                is_tick;

   assign pop = q_valid && (!rsp_valid_ff || rsp_ready);
   assign stop_mode = cfg.stop_brake ? MODE_HIGH : MODE_LOW;
   assign is_tick = (q_head.op == OP_TICK);

   always_comb begin
      counter_in = counter_ff;
      mode_in    = mode_ff;
      shadow_in  = shadow_ff;
      active_in  = active_ff;
      awake_in   = awake_ff;
      counter_nxt = counter_ff + CNT_W'(1);
      if (CMP_W'(counter_nxt) >= CMP_W'(cfg.pwm_period)) begin
         counter_nxt = '0;
      end
      if (pop) begin
         case (q_head.op)
            OP_TICK: begin
               counter_in = counter_nxt;
               if (counter_nxt == '0) begin
                  active_in = shadow_ff;
               end
            end
            OP_SET: begin
               for (int b = 0; b < 2; b++) begin
                  if (q_head.br[b].stop) begin
                     mode_in[2*b]   = stop_mode;
                     mode_in[2*b+1] = stop_mode;
                  end else if (q_head.br[b].fwd) begin
                     mode_in[2*b]     = MODE_HIGH;
                     mode_in[2*b+1]   = MODE_PWM;
                     shadow_in[2*b+1] = q_head.br[b].cmp;
                  end else begin
                     mode_in[2*b+1] = MODE_HIGH;
                     mode_in[2*b]   = MODE_PWM;
                     shadow_in[2*b] = q_head.br[b].cmp;
                  end
               end
            end
            OP_COAST: mode_in = {4{MODE_LOW}};
            OP_BRAKE: mode_in = {4{MODE_HIGH}};
            OP_SLEEP: begin
               mode_in  = {4{MODE_LOW}};
               awake_in = 1'b0;
            end
            OP_WAKE: awake_in = 1'b1;
            default: ;
         endcase
      end

      for (int g = 0; g < 4; g++) begin
         case (mode_in[g])
            MODE_HIGH: level[g] = 1'b1;
            MODE_PWM:  level[g] = CMP_W'(counter_in) < CMP_W'(active_in[g]);
            default:   level[g] = 1'b0;
         endcase
      end

      rsp_data_in.left_in1  = level[0];
      rsp_data_in.left_in2  = level[1];
      rsp_data_in.right_in1 = level[2];
      rsp_data_in.right_in2 = level[3];
      rsp_data_in.sleep_n   = awake_in;

      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff   <= '0;
         mode_ff      <= {4{MODE_LOW}};
         shadow_ff    <= '0;
         active_ff    <= '0;
         awake_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         counter_ff   <= counter_in;
         mode_ff      <= mode_in;
         shadow_ff    <= shadow_in;
         active_ff    <= active_in;
         awake_ff     <= awake_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_sleep_coasts: assert property (@(posedge clock) disable iff (reset)
      (pop && q_head.op == OP_SLEEP) |=> rsp_valid_ff && (rsp_data_ff == '0))
      else $error("sleep did not coast all pins");
   a_wrap_loads: assert property (@(posedge clock) disable iff (reset)
      (pop && is_tick && counter_nxt == '0) |=> (active_ff == shadow_ff))
      else $error("compares not loaded at counter zero");
`endif

endmodule

FILE: tb/tb.sv
// tb: self-checking testbench for dual_hbridge_slow_decay_pwm.
// Depends on rtl/dhb_pkg.sv and rtl/dual_hbridge_slow_decay_pwm.sv.
`timescale 1ns / 1ps

module tb;
   import dhb_pkg::*;

   // spare opcode values the block must ignore
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;

   // cycles with no transaction on either side before the run is abandoned
   localparam int STALL_LIMIT = 3000;
   // long receiver hold-off used to back up the command queue
   localparam int HOLD_CYCLES = 80;

   // -------------------------------------------------------------------------
   // Pin predictor and result store. Keeps its own copy of the registers,
   // the shared PWM counter, the four generators and the sleep flag.
   // -------------------------------------------------------------------------
   class pin_scoreboard;
      bit [15:0] period;
      bit [9:0]  deadband;
      bit        brake;
      bit [15:0] counter;
      mode_type  mode[4];
      bit [15:0] shadow[4];
      bit [15:0] active[4];
      bit        awake;
      rsp_type   pin_q[$];
      int        mismatches;

      function new();
         period = PERIOD_RESET;
         deadband = '0;
         brake = 1'b0;
         counter = '0;
         awake = 1'b1;
         mismatches = 0;
         for (int i = 0; i < 4; i++) begin
            mode[i] = MODE_LOW;
            shadow[i] = '0;
            active[i] = '0;
         end
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] val);
         case (idx)
            CSR_PERIOD:   period = val;
            CSR_DEADBAND: deadband = val[9:0];
            CSR_BRAKE:    brake = val[0];
            default: ;
         endcase
      endfunction

      function int pending();
         return pin_q.size();
      endfunction

      // one bridge of a set command; base 0 = left, 2 = right
      function void drive_bridge(int base, logic signed [15:0] cmd);
         int          v;
         int unsigned mag;
         int unsigned p;
         int unsigned duty;
         int          drv;
         int          chop;
         v = cmd;
         if (v < -1000) v = -1000;
         if (v > 1000) v = 1000;
         mag = (v < 0) ? -v : v;
         if (deadband != 0 && mag < deadband) mag = 0;
         p = period;
         duty = (mag * p) / 1000;
         if (mag == 0 || duty == 0) begin
            mode[base] = brake ? MODE_HIGH : MODE_LOW;
            mode[base+1] = brake ? MODE_HIGH : MODE_LOW;
            return;
         end
         // forward holds in1 high and chops in2; reverse is the mirror
         drv = (v > 0) ? base : base + 1;
         chop = (v > 0) ? base + 1 : base;
         mode[drv] = MODE_HIGH;
         mode[chop] = MODE_PWM;
         shadow[chop] = 16'(p - duty);
      endfunction

      function bit level(int g);
         case (mode[g])
            MODE_HIGH: return 1'b1;
            MODE_PWM:  return counter < active[g];
            default:   return 1'b0;
         endcase
      endfunction

      function void advance();
         bit [15:0] nxt;
         nxt = counter + 16'd1;
         if (nxt >= period) nxt = '0;
         counter = nxt;
         if (counter == 0) begin
            for (int i = 0; i < 4; i++) active[i] = shadow[i];
         end
      endfunction

      // accepted command transaction: update state, queue the pin levels
      function void note_request(req_type r);
         rsp_type e;
         case (r.opcode)
            OP_TICK:  advance();
            OP_SET: begin
               drive_bridge(0, r.left_command);
               drive_bridge(2, r.right_command);
            end
            OP_COAST: for (int i = 0; i < 4; i++) mode[i] = MODE_LOW;
            OP_BRAKE: for (int i = 0; i < 4; i++) mode[i] = MODE_HIGH;
            OP_SLEEP: begin
               for (int i = 0; i < 4; i++) mode[i] = MODE_LOW;
               awake = 1'b0;
            end
            OP_WAKE:  awake = 1'b1;
            default: ;
         endcase
         e.left_in1 = level(0);
         e.left_in2 = level(1);
         e.right_in1 = level(2);
         e.right_in2 = level(3);
         e.sleep_n = awake;
         pin_q.push_back(e);
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         bit      bad;
         if (pin_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response with nothing outstanding: %b", $realtime, got);
            return;
         end
         e = pin_q.pop_front();
         bad = (got.left_in1 !== e.left_in1) || (got.left_in2 !== e.left_in2) ||
               (got.right_in1 !== e.right_in1) || (got.right_in2 !== e.right_in2) ||
               (got.sleep_n !== e.sleep_n);
         if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: pins expected l1=%b l2=%b r1=%b r2=%b sleep_n=%b",
                        $realtime, e.left_in1, e.left_in2, e.right_in1,
                        e.right_in2, e.sleep_n);
               $display("%0t: pins got      l1=%b l2=%b r1=%b r2=%b sleep_n=%b",
                        $realtime, got.left_in1, got.left_in2, got.right_in1,
                        got.right_in2, got.sleep_n);
            end
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block instance
   // -------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   always #4 clock = ~clock;

   dual_hbridge_slow_decay_pwm dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   pin_scoreboard sb = new();

   bit steady = 1'b0;   // no idling on either side while set
   int hold_req = 0;    // main asks the receiver for a long hold-off here

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // -------------------------------------------------------------------------
   // Result side: checks every response transaction, idles at random and
   // does the long hold-off that main asks for.
   // -------------------------------------------------------------------------
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
         if (hold_req > 0) begin
            stall = hold_req;
            hold_req = 0;
         end
         if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else if (steady || $urandom_range(0, 99) < 70) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            stall = pick_gap();
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: abandon the run when nothing moves for too long
   // -------------------------------------------------------------------------
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("FAIL dual_hbridge_slow_decay_pwm");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Drivers. All are entered right after a rising edge.
   // -------------------------------------------------------------------------

   // offer one command, hold it until taken, then idle for gap cycles
   task automatic send_item(req_type r, int gap);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // all three registers back to back; upper bits of the narrow ones are junk
   task automatic write_regs(logic [15:0] period, logic [9:0] db, logic brk);
      logic [15:0] db_word;
      logic [15:0] brk_word;
      db_word = {6'($urandom), db};
      brk_word = {15'($urandom), brk};
      csr_write_en <= 1'b1;
      csr_index <= CSR_PERIOD;
      csr_wdata <= period;
      @(posedge clock);
      csr_index <= CSR_DEADBAND;
      csr_wdata <= db_word;
      @(posedge clock);
      csr_index <= CSR_BRAKE;
      csr_wdata <= brk_word;
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.write_reg(CSR_PERIOD, period);
      sb.write_reg(CSR_DEADBAND, db_word);
      sb.write_reg(CSR_BRAKE, brk_word);
   endtask

   // wait until every expected transaction is back, plus the pipeline depth
   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   function automatic req_type mk(logic [2:0] op, int l, int r);
      req_type it;
      it.opcode = op;
      it.left_command = 16'(l);
      it.right_command = 16'(r);
      return it;
   endfunction

   // speeds: full 16-bit range, the clamp window, corner values, deadband edge
   function automatic logic signed [15:0] pick_command(int db);
      int r;
      int tmp;
      r = $urandom_range(0, 99);
      if (r < 30) return 16'($urandom);
      if (r < 70) begin
         tmp = int'($urandom_range(0, 2200)) - 1100;
         return 16'(tmp);
      end
      if (r < 82) begin
         case ($urandom_range(0, 9))
            0: tmp = -32768;
            1: tmp = 32767;
            2: tmp = 1000;
            3: tmp = -1000;
            4: tmp = 1001;
            5: tmp = -1001;
            6: tmp = 0;
            7: tmp = 1;
            8: tmp = -1;
            default: tmp = 999;
         endcase
         return 16'(tmp);
      end
      tmp = db + int'($urandom_range(0, 4)) - 2;
      if ($urandom_range(0, 1)) tmp = -tmp;
      return 16'(tmp);
   endfunction

   // mostly ticks so the counter wraps, sets often enough to keep PWM live
   function automatic req_type pick_item(int db);
      req_type it;
      int      r;
      r = $urandom_range(0, 99);
      it.left_command = pick_command(db);
      it.right_command = pick_command(db);
      if (r < 65) it.opcode = OP_TICK;
      else if (r < 85) it.opcode = OP_SET;
      else if (r < 88) it.opcode = OP_COAST;
      else if (r < 91) it.opcode = OP_BRAKE;
      else if (r < 94) it.opcode = OP_SLEEP;
      else if (r < 98) it.opcode = OP_WAKE;
      else it.opcode = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
      return it;
   endfunction

   // one register setting followed by a run of random commands
   task automatic run_phase(int id, logic [15:0] period, logic [9:0] db, logic brk,
                            int count, bit quiet);
      int gap;
      write_regs(period, db, brk);
      steady = quiet;
      for (int i = 0; i < count; i++) begin
         gap = steady ? 0 : pick_gap();
         // back up the queue: receiver holds off, sender keeps offering
         if (id == 2 && i == 40) hold_req = HOLD_CYCLES;
         if (id == 2 && i >= 40 && i < 90) gap = 0;
         // sender stops mid-phase until everything is back
         if (id == 3 && i == 50) gap = 1;
         send_item(pick_item(db), gap);
         if (id == 3 && i == 50) wait_drained();
      end
      req_valid <= 1'b0;
      wait_drained();
      steady = 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int leftover;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: period 500, coast on stop
      send_item(mk(OP_TICK, 0, 0), 0);
      send_item(mk(OP_SET, 250, -250), 0);
      send_item(mk(OP_TICK, 0, 0), 2);
      req_valid <= 1'b0;
      wait_drained();

      // directed: short period so the compares load within a few ticks
      write_regs(16'd10, 10'd0, 1'b0);
      send_item(mk(OP_SET, 32767, -32768), 0);     // clamp both extremes
      send_item(mk(OP_SET, 1000, -1000), 0);       // full duty -> compare 0
      send_item(mk(OP_SET, 500, -1), 1);           // tiny reverse: duty 0, stop
      send_item(mk(OP_SET, 1001, -1001), 0);
      send_item(mk(OP_COAST, 0, 0), 0);
      send_item(mk(OP_BRAKE, 0, 0), 3);
      send_item(mk(OP_SLEEP, 0, 0), 0);
      send_item(mk(OP_SET, 300, -300), 0);         // set while asleep
      send_item(mk(OP_WAKE, 0, 0), 0);
      send_item(mk(OP_SPARE_A, 123, -45), 0);
      send_item(mk(OP_SPARE_B, -1, 1), 0);
      send_item(mk(OP_SET, 0, 0), 0);
      send_item(mk(OP_SET, 400, -700), 0);
      for (int i = 0; i < 12; i++) send_item(mk(OP_TICK, 0, 0), 0);
      req_valid <= 1'b0;
      wait_drained();

      // random phases; counter state carries over between settings
      run_phase(1, 16'd10, 10'd0, 1'b0, 250, 1'b1);
      run_phase(2, 16'd13, 10'd1000, 1'b1, 200, 1'b0);
      run_phase(3, 16'd0, 10'd5, 1'b0, 100, 1'b0);       // counter pinned at 0
      run_phase(4, 16'd65535, 10'd0, 1'b0, 200, 1'b0);   // compares beyond range
      run_phase(5, 16'd20, 10'd3, 1'b1, 200, 1'b0);      // counter above new period
      run_phase(6, 16'd17, 10'd1023, 1'b1, 150, 1'b0);   // everything is a stop
      for (int p = 0; p < 4; p++) begin
         run_phase(7 + p, 16'($urandom_range(10, 64)),
                   $urandom_range(0, 1) ? 10'($urandom_range(0, 1023)) : 10'd0,
                   1'($urandom), 160, p == 2);
      end

      leftover = sb.pending();
      if (leftover != 0) $display("%0d expected transactions never arrived", leftover);
      if (sb.mismatches == 0 && leftover == 0) begin
         $display("PASS dual_hbridge_slow_decay_pwm");
      end else begin
         $display("FAIL dual_hbridge_slow_decay_pwm");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/dhb_pkg.sv
rtl/dhb_front.sv
rtl/dhb_fifo.sv
rtl/dhb_back.sv
rtl/dual_hbridge_slow_decay_pwm.sv
tb/tb.sv
